// File: hw/rtl/rcb_pkg.sv
// ----------------------------------------------------------------------------
// rcb_pkg
// shared types and constants for the range count below block
// ----------------------------------------------------------------------------
package rcb_pkg;

	localparam int IDX_W   = 10;
	localparam int VAL_W   = 32;
	localparam int DEPTH   = 1024;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = 11;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic                    present;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_entry;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/rcb_store.sv
// ----------------------------------------------------------------------------
// rcb_store
// slot memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rcb_store (
	input  logic              clk,
	input  rcb_pkg::mem_req_t req,
	output rcb_pkg::entry_t   rd_entry
);

	rcb_pkg::entry_t mem [rcb_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_entry <= mem[req.rd_addr];
		end
	end

endmodule

// File: hw/rtl/range_count_below_updatable_top.sv
// ----------------------------------------------------------------------------
// range_count_below_updatable_top
// indexed store of signed values with a present mark per slot; counts the
// present slots in an index range whose value lies below a threshold
// ----------------------------------------------------------------------------
//
// channel   dir  handshake             fields
// request   in   start & !busy         req_type, slot_index, write_value,
//                                      range_low, range_high, threshold
// result    out  done, one cycle       below_count
//
// a write leaves busy low, so items can follow back to back
// a query scans its range through the single read port of the slot memory,
// one slot per cycle, then drains; an empty range goes straight to done
// after reset a clearing pass over all 1024 slots marks every slot absent, busy high
// the result strobe cannot be held off; done is high for exactly one cycle
//
module range_count_below_updatable_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [rcb_pkg::IDX_W-1:0]          slot_index,
	input  logic signed [rcb_pkg::VAL_W-1:0]   write_value,
	input  logic [rcb_pkg::IDX_W-1:0]          range_low,
	input  logic [rcb_pkg::IDX_W-1:0]          range_high,
	input  logic signed [rcb_pkg::VAL_W-1:0]   threshold,
	output logic                               done,
	output logic [rcb_pkg::COUNT_W-1:0]        below_count
);

	// depth and last slot as index-plus-one wide numbers for range checks
	localparam logic [rcb_pkg::IDX_W:0] DEPTH_X = (rcb_pkg::IDX_W + 1)'(rcb_pkg::DEPTH);
	localparam logic [rcb_pkg::IDX_W:0] LAST_X  = (rcb_pkg::IDX_W + 1)'(rcb_pkg::DEPTH - 1);
	localparam logic [rcb_pkg::ADDR_W-1:0] LAST_A = rcb_pkg::ADDR_W'(rcb_pkg::DEPTH - 1);

	rcb_pkg::state_t   state_q, state_d;
	rcb_pkg::mem_req_t mem_req;
	rcb_pkg::entry_t   rd_entry;

	logic [rcb_pkg::ADDR_W-1:0]        addr_q;   // clear or scan pointer
	logic [rcb_pkg::ADDR_W-1:0]        hi_q;     // last slot of the scan
	logic signed [rcb_pkg::VAL_W-1:0]  thr_q;
	logic [rcb_pkg::COUNT_W-1:0]       count_q;
	logic                              vld_s1;   // read data in rd_entry is a scan slot

	logic                              accept;
	logic                              is_query;
	logic                              is_write;
	logic [rcb_pkg::IDX_W:0]           hi_x;     // range_high clamped to the last slot
	logic [rcb_pkg::IDX_W:0]           lo_x;
	logic                              range_ok;
	logic                              hit;
	logic                              scan_last;
	logic                              clear_last;

	assign accept     = start && !busy;
	assign is_query   = accept && (req_type == rcb_pkg::REQ_QUERY);
	assign is_write   = accept && (req_type == rcb_pkg::REQ_WRITE);
	assign lo_x       = {1'b0, range_low};
	assign hi_x       = ({1'b0, range_high} >= DEPTH_X) ? LAST_X : {1'b0, range_high};
	assign range_ok   = (lo_x <= hi_x) && (lo_x < DEPTH_X);
	assign scan_last  = (addr_q == hi_q);
	assign clear_last = (addr_q == LAST_A);

	// slot counts when marked present and its value is below the threshold
	assign hit = vld_s1 && rd_entry.present && (rd_entry.value < thr_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcb_pkg::ST_CLEAR: begin
				if (clear_last) state_d = rcb_pkg::ST_IDLE;
			end
			rcb_pkg::ST_IDLE: begin
				if (is_query) state_d = range_ok ? rcb_pkg::ST_SCAN : rcb_pkg::ST_DONE;
			end
			rcb_pkg::ST_SCAN: begin
				if (scan_last) state_d = rcb_pkg::ST_DRAIN;
			end
			rcb_pkg::ST_DRAIN: begin
				state_d = rcb_pkg::ST_DONE;
			end
			rcb_pkg::ST_DONE: begin
				state_d = rcb_pkg::ST_IDLE;
			end
			default: state_d = rcb_pkg::ST_CLEAR;
		endcase
	end

	// outputs and memory port control
	always_comb begin
		busy             = 1'b1;
		done             = 1'b0;
		mem_req.wr_en    = 1'b0;
		mem_req.wr_addr  = addr_q;
		mem_req.wr_entry = '0;
		mem_req.rd_en    = 1'b0;
		mem_req.rd_addr  = addr_q;
		unique case (state_q)
			rcb_pkg::ST_CLEAR: begin
				// sweep marks every slot absent
				mem_req.wr_en = 1'b1;
			end
			rcb_pkg::ST_IDLE: begin
				busy = 1'b0;
				// a write past the last slot is dropped
				if (is_write && ({1'b0, slot_index} < DEPTH_X)) begin
					mem_req.wr_en            = 1'b1;
					mem_req.wr_addr          = slot_index[rcb_pkg::ADDR_W-1:0];
					mem_req.wr_entry.present = 1'b1;
					mem_req.wr_entry.value   = write_value;
				end
			end
			rcb_pkg::ST_SCAN: begin
				mem_req.rd_en = 1'b1;
			end
			rcb_pkg::ST_DRAIN: begin
			end
			rcb_pkg::ST_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign below_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcb_pkg::ST_CLEAR;
			addr_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == rcb_pkg::ST_SCAN);
			if (state_q == rcb_pkg::ST_IDLE) begin
				addr_q <= range_low[rcb_pkg::ADDR_W-1:0];
			end else if ((state_q == rcb_pkg::ST_CLEAR) || (state_q == rcb_pkg::ST_SCAN)) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	// query payload and running count
	always_ff @(posedge clk) begin
		if (is_query) begin
			hi_q    <= hi_x[rcb_pkg::ADDR_W-1:0];
			thr_q   <= threshold;
			count_q <= '0;
		end else if (hit) begin
			count_q <= count_q + 1'b1;
		end
	end

	rcb_store u_store (
		.clk      (clk),
		.req      (mem_req),
		.rd_entry (rd_entry)
	);

endmodule

// File: tb/range_count_below_checker.sv
// ----------------------------------------------------------------------------
// range_count_below_checker
// watches the request and result channels of the range count block, keeps its
// own copy of the slot store and compares every count with its prediction
// ----------------------------------------------------------------------------
module range_count_below_checker
	import rcb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      req_type,
	input  logic [IDX_W-1:0]          slot_index,
	input  logic signed [VAL_W-1:0]   write_value,
	input  logic [IDX_W-1:0]          range_low,
	input  logic [IDX_W-1:0]          range_high,
	input  logic signed [VAL_W-1:0]   threshold,
	input  logic                      done,
	input  logic [COUNT_W-1:0]        below_count,
	output int                        fail_count,
	output int                        pending
);

	logic signed [VAL_W-1:0] slot_val [DEPTH];
	logic                    slot_mark [DEPTH];
	logic [COUNT_W-1:0]      awaited_counts [$];
	logic [COUNT_W-1:0]      want;

	// only marked slots are read, so unwritten values never matter
	function automatic logic [COUNT_W-1:0] count_below(input logic [IDX_W-1:0] lo,
			input logic [IDX_W-1:0] hi, input logic signed [VAL_W-1:0] limit);
		logic [COUNT_W-1:0] n;
		n = '0;
		if (lo <= hi)
			for (int i = int'(lo); i <= int'(hi); i++)
				if (slot_mark[i] && slot_val[i] < limit)
					n++;
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				slot_mark[i] = 1'b0;
			awaited_counts.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// results first: a count leaving now belongs to an older query
			if (done) begin
				if (awaited_counts.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected count: below_count=%0d", below_count);
				end else begin
					want = awaited_counts.pop_front();
					if (below_count !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("count mismatch: expected %0d, got %0d", want,
								below_count);
					end
				end
			end
			if (start && !busy) begin
				if (req_type == REQ_WRITE) begin
					slot_val[slot_index] = write_value;
					slot_mark[slot_index] = 1'b1;
				end else begin
					awaited_counts = {awaited_counts,
						count_below(range_low, range_high, threshold)};
				end
			end
			pending = awaited_counts.size();
		end
	end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives directed items, then random bursts of writes and range count queries,
// into the range count block; a checker beside the block predicts every count and compares
// ----------------------------------------------------------------------------
module testbench;
	import rcb_pkg::*;

	localparam int RANDOM_ITEMS = 560;
	localparam int WINDOW       = 64;
	localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    req_type;
	logic [IDX_W-1:0]        slot_index;
	logic signed [VAL_W-1:0] write_value;
	logic [IDX_W-1:0]        range_low;
	logic [IDX_W-1:0]        range_high;
	logic signed [VAL_W-1:0] threshold;
	logic                    done;
	logic [COUNT_W-1:0]      below_count;
	int                      fail_count;
	int                      pending;

	// recently written values, used to put thresholds right on stored values
	logic signed [VAL_W-1:0] recent_vals [8];

	always #1 clk = ~clk;

	range_count_below_updatable_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.slot_index  (slot_index),
		.write_value (write_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.threshold   (threshold),
		.done        (done),
		.below_count (below_count)
	);

	range_count_below_checker count_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.slot_index  (slot_index),
		.write_value (write_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.threshold   (threshold),
		.done        (done),
		.below_count (below_count),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// present one item and hold it until the block takes it
	// called at a rising edge; returns at the edge that accepted the item
	task automatic send_item(input logic kind, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val, input logic [IDX_W-1:0] lo,
			input logic [IDX_W-1:0] hi, input logic signed [VAL_W-1:0] thr);
		start       <= 1'b1;
		req_type    <= kind;
		slot_index  <= idx;
		write_value <= val;
		range_low   <= lo;
		range_high  <= hi;
		threshold   <= thr;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// generous hard stop: worst case is every item a full-range query
	initial begin
		#8000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int sent;
		int burst;
		int gap;
		int calm_bursts;
		int next_drain;
		int win_base;
		int pick;
		int val_i;
		int thr_i;
		int lo_i;
		int hi_i;
		int span;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		req_type    <= REQ_WRITE;
		slot_index  <= '0;
		write_value <= '0;
		range_low   <= '0;
		range_high  <= '0;
		threshold   <= '0;
		for (int i = 0; i < 8; i++)
			recent_vals[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---------------- directed part ----------------
		// the clearing pass after reset keeps busy high; send_item just waits
		// empty store counts nothing, even with the largest threshold
		send_item(REQ_QUERY, 0, 0, 0, LAST_IDX, VMAX);
		// extremes of value at the extremes of index
		send_item(REQ_WRITE, 0, VMIN, 0, 0, 0);
		send_item(REQ_WRITE, LAST_IDX, VMAX, 0, 0, 0);
		send_item(REQ_WRITE, 512, -1, 0, 0, 0);
		send_item(REQ_WRITE, 513, 0, 0, 0, 0);
		send_item(REQ_WRITE, 1, 1, 0, 0, 0);
		// whole range against thresholds on both sides of zero
		send_item(REQ_QUERY, 0, 0, 0, LAST_IDX, VMAX);
		send_item(REQ_QUERY, 0, 0, 0, LAST_IDX, VMIN);
		send_item(REQ_QUERY, 0, 0, 0, LAST_IDX, 0);
		send_item(REQ_QUERY, 0, 0, 0, LAST_IDX, -1);
		// inverted ranges count zero
		send_item(REQ_QUERY, 0, 0, 600, 5, VMAX);
		send_item(REQ_QUERY, 0, 0, LAST_IDX, 0, VMAX);
		// a value equal to the threshold is not below it
		send_item(REQ_QUERY, 0, 0, LAST_IDX, LAST_IDX, VMAX);
		send_item(REQ_QUERY, 0, 0, 512, 513, 1);
		// rewrite a slot, then probe around its new value
		send_item(REQ_WRITE, 512, 5, 0, 0, 0);
		send_item(REQ_QUERY, 0, 0, 512, 512, 5);
		send_item(REQ_QUERY, 0, 0, 512, 512, 6);
		send_item(REQ_QUERY, 0, 0, 0, 0, VMIN + 1);
		// stretch with no present slot
		send_item(REQ_QUERY, 0, 0, 2, 511, VMAX);
		// unused fields set to junk on both item kinds
		send_item(REQ_WRITE, LAST_IDX - 1'b1, VMIN, LAST_IDX, 3, VMAX);
		send_item(REQ_QUERY, 7, VMAX, LAST_IDX - 1'b1, LAST_IDX, 0);

		// let every directed count come back before the random part
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		// ---------------- random part ----------------
		// most items write into and query a moving 64-slot window, so counts
		// land on populated stretches; a few are unconstrained noise
		sent        = 0;
		calm_bursts = 0;
		next_drain  = 150;
		win_base    = $urandom_range(0, DEPTH - WINDOW);
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 16);
			for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
				// value: mostly small so equal values recur, else any or an extreme
				pick = $urandom_range(0, 9);
				if (pick < 6)
					val_i = int'($urandom_range(0, 200)) - 100;
				else if (pick < 8)
					val_i = $urandom;
				else if (pick == 8)
					val_i = VMIN;
				else
					val_i = VMAX;
				// threshold: on, next to, or away from a stored value
				pick = $urandom_range(0, 9);
				if (pick < 4)
					thr_i = recent_vals[$urandom_range(0, 7)];
				else if (pick < 6)
					thr_i = recent_vals[$urandom_range(0, 7)] + (pick == 4 ? 1 : -1);
				else if (pick < 8)
					thr_i = int'($urandom_range(0, 200)) - 100;
				else if (pick == 8)
					thr_i = $urandom;
				else
					thr_i = $urandom_range(0, 1) ? VMIN : VMAX;

				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// noise: anything the fields allow, inverted ranges included
					send_item(1'($urandom_range(0, 1)), IDX_W'($urandom), $urandom,
						IDX_W'($urandom), IDX_W'($urandom), $urandom);
				end else if (pick < 50) begin
					send_item(REQ_WRITE,
						IDX_W'(win_base + int'($urandom_range(0, WINDOW - 1))), val_i,
						IDX_W'($urandom), IDX_W'($urandom), $urandom);
					recent_vals[$urandom_range(0, 7)] = val_i;
				end else begin
					// short spans keep the scan quick; a few long and full ones
					pick = $urandom_range(0, 99);
					if (pick < 3) begin
						lo_i = 0;
						hi_i = DEPTH - 1;
					end else begin
						span = (pick < 85) ? $urandom_range(0, 15)
							: $urandom_range(0, WINDOW - 1);
						lo_i = win_base + $urandom_range(0, WINDOW - 1);
						hi_i = lo_i + span;
						if (hi_i > DEPTH - 1)
							hi_i = DEPTH - 1;
					end
					send_item(REQ_QUERY, IDX_W'($urandom), $urandom, IDX_W'(lo_i),
						IDX_W'(hi_i), thr_i);
				end
				sent++;
				// move the window now and then, sometimes onto the array ends
				if (sent % 70 == 0) begin
					pick = $urandom_range(0, 3);
					win_base = (pick == 0) ? 0 : (pick == 1) ? DEPTH - WINDOW
						: $urandom_range(0, DEPTH - WINDOW);
				end
			end

			// gap after the burst; calm stretches run bursts back to back
			if (calm_bursts > 0) begin
				calm_bursts--;
				gap = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				calm_bursts = $urandom_range(3, 8);
				gap = 0;
			end else begin
				gap = $urandom_range(0, 12);
			end

			if (sent >= next_drain) begin
				// hold off until every outstanding count has come back
				start <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
				next_drain += 150;
			end else if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		// ---------------- wind down ----------------
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		// a full scan plus its overhead, to catch any stray count
		repeat (DEPTH + 16) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rcb_pkg.sv
hw/rtl/rcb_store.sv
hw/rtl/range_count_below_updatable_top.sv
tb/range_count_below_checker.sv
tb/testbench.sv
